// ===== hdl/ate_pkg.sv =====
`default_nettype none
package ate_pkg;
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_QUERY   = 2'd1,
		OP_REPLY   = 2'd2,
		OP_REQUEST = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_RESOLVED = 3'd0,
		ST_PENDING  = 3'd1,
		ST_UPDATED  = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_FULL     = 3'd4,
		ST_TICKDONE = 3'd5
	} status_t;

	localparam logic [1:0] ENT_EMPTY   = 2'd0;
	localparam logic [1:0] ENT_PENDING = 2'd1;
	localparam logic [1:0] ENT_STABLE  = 2'd2;

	localparam logic [1:0] REG_OWN_IP      = 2'd0;
	localparam logic [1:0] REG_STABLE_LIM  = 2'd1;
	localparam logic [1:0] REG_PENDING_LIM = 2'd2;

	// entry word: {age, mac, ip, state}
	localparam int ENTRY_W = 8 + 48 + 32 + 2;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_CLEAR,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_WRITE,
		FSM_OUT
	} fsm_t;
endpackage
`default_nettype wire

// ===== hdl/ate_ram.sv =====
`default_nettype none
module ate_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/arp_table_engine_core.sv =====
`default_nettype none
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tdata: op, ip_addr, mac_addr, target_ip
// m_axis    out  m_axis_tvalid/tready     tdata: status, mac_out, entry_index,
//                                               send_request, send_reply
// cfg       in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// After reset a clearing pass writes every entry empty.
// Every item scans the whole table: the read of entry 0 issues at the accepting
// edge, then come the scan state (a tick writes each aged entry back in the cycle
// after its read), the decide state, the write state and the output state.
// A new item is accepted only in the idle state, which the engine enters once
// the previous result has been loaded into the output register.
// The output register parts the sides: a stalled result holds only the output
// cycle, so the next item scans while the previous result waits.
module arp_table_engine_core #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// [1:0] op, [33:2] ip_addr, [81:34] mac_addr, [113:82] target_ip, zero pad
	input  wire logic [119:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [2:0] status, [50:3] mac_out, [54:51] entry_index,
	// [55] send_request, [56] send_reply, zero pad
	output logic [63:0]       m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

	// configuration registers
	logic [31:0] own_ip_q;
	logic [7:0]  stable_lim_q, pending_lim_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= '0;
			stable_lim_q  <= 8'd120;
			pending_lim_q <= 8'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				ate_pkg::REG_OWN_IP:      own_ip_q      <= cfg_data;
				ate_pkg::REG_STABLE_LIM:  stable_lim_q  <= cfg_data[7:0];
				ate_pkg::REG_PENDING_LIM: pending_lim_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// table memory
	logic                        we;
	logic [AW-1:0]               waddr, raddr;
	logic [ate_pkg::ENTRY_W-1:0] wdata, rdata;

	ate_ram #(.WIDTH(ate_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [1:0]  r_state;
	logic [31:0] r_ip;
	logic [47:0] r_mac;
	logic [7:0]  r_age;
	assign r_state = rdata[1:0];
	assign r_ip    = rdata[33:2];
	assign r_mac   = rdata[81:34];
	assign r_age   = rdata[89:82];

	// item registers
	ate_pkg::op_t op_q;
	logic [31:0] ip_q, tgt_q;
	logic [47:0] mac_q;

	// cache
	logic        c_valid_q, c_idx_valid_q;
	logic [31:0] c_ip_q;
	logic [47:0] c_mac_q;
	logic [AW-1:0] c_idx_q;

	// scan bookkeeping
	ate_pkg::fsm_t st_q, st_d;
	logic [CW-1:0] cnt_q;     // read address counter
	logic          rv_q;      // rdata valid for entry rd_idx_q
	logic [AW-1:0] rd_idx_q;
	logic          hit_q, emp_q, stb_q, pnd_q;
	logic [AW-1:0] hit_idx_q, emp_idx_q, stb_idx_q, pnd_idx_q;
	logic [7:0]    stb_age_q, pnd_age_q;
	logic [1:0]    hit_st_q;
	logic [47:0]   hit_mac_q;
	// contents of the entry the cache points at, seen during the scan
	logic [1:0]    ce_st_q;
	logic [31:0]   ce_ip_q;
	logic [47:0]   ce_mac_q;
	// chosen entry and write word
	logic [AW-1:0] pick_q;
	logic [ate_pkg::ENTRY_W-1:0] wword_q;
	logic          wen_q;
	// result: decided word, then output register
	logic [63:0]   dec_res_q;
	logic [63:0]   res_q;
	logic          ovalid_q;
	logic          out_load;

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = res_q;
	assign s_axis_tready = (st_q == ate_pkg::FSM_IDLE);
	// output register free or emptied this cycle
	assign out_load = (st_q == ate_pkg::FSM_OUT) && (!ovalid_q || m_axis_tready);

	// tick evaluation of the entry now on rdata
	logic [7:0] t_age;
	logic       t_exp;
	always_comb begin
		t_age = (r_age == 8'hFF) ? r_age : r_age + 8'd1;
		t_exp = ((r_state == ate_pkg::ENT_STABLE) && (t_age > stable_lim_q)) ||
			((r_state == ate_pkg::ENT_PENDING) && (t_age > pending_lim_q));
	end

	logic rx_ok, c_hit_rx;
	assign rx_ok    = (own_ip_q != 32'd0) && (tgt_q == own_ip_q);
	assign c_hit_rx = c_valid_q && (ip_q == c_ip_q) && (mac_q == c_mac_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ate_pkg::FSM_IDLE:   if (s_axis_tvalid && s_axis_tready) st_d = ate_pkg::FSM_SCAN;
			ate_pkg::FSM_CLEAR:  if (cnt_q == LAST) st_d = ate_pkg::FSM_IDLE;
			ate_pkg::FSM_SCAN:   if (rv_q && rd_idx_q == LAST[AW-1:0]) st_d = ate_pkg::FSM_DECIDE;
			ate_pkg::FSM_DECIDE: st_d = ate_pkg::FSM_WRITE;
			ate_pkg::FSM_WRITE:  st_d = ate_pkg::FSM_OUT;
			ate_pkg::FSM_OUT:    if (out_load) st_d = ate_pkg::FSM_IDLE;
			default:             st_d = ate_pkg::FSM_IDLE;
		endcase
	end

	// memory port: clear pass, tick write-back during scan, or final write
	always_comb begin
		raddr = cnt_q[AW-1:0];
		we    = 1'b0;
		waddr = rd_idx_q;
		wdata = '0;
		if (st_q == ate_pkg::FSM_CLEAR) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
		end else if (st_q == ate_pkg::FSM_SCAN && op_q == ate_pkg::OP_TICK && rv_q &&
			r_state != ate_pkg::ENT_EMPTY) begin
			we = 1'b1;
			if (!t_exp)
				wdata = {t_age, r_mac, r_ip, r_state};
		end else if (st_q == ate_pkg::FSM_WRITE && wen_q) begin
			we    = 1'b1;
			waddr = pick_q;
			wdata = wword_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ate_pkg::FSM_CLEAR;
			cnt_q         <= '0;
			rv_q          <= 1'b0;
			ovalid_q      <= 1'b0;
			c_valid_q     <= 1'b0;
			c_idx_valid_q <= 1'b0;
			c_ip_q        <= '0;
			c_mac_q       <= '0;
			c_idx_q       <= '0;
		end else begin
			st_q <= st_d;
			if (out_load)
				ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready)
				ovalid_q <= 1'b0;
			case (st_q)
				ate_pkg::FSM_CLEAR: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + CW'(1);
				end
				ate_pkg::FSM_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						cnt_q <= CW'(1);
						rv_q  <= 1'b1;
					end else begin
						cnt_q <= '0;
						rv_q  <= 1'b0;
					end
				end
				ate_pkg::FSM_SCAN: begin
					if (cnt_q <= LAST)
						cnt_q <= cnt_q + CW'(1);
					rv_q <= (cnt_q <= LAST);
					if (op_q == ate_pkg::OP_TICK && rv_q && r_state != ate_pkg::ENT_EMPTY &&
						t_exp && c_valid_q && c_ip_q == r_ip) begin
						c_valid_q     <= 1'b0;
						c_idx_valid_q <= 1'b0;
						c_ip_q        <= '0;
						c_mac_q       <= '0;
						c_idx_q       <= '0;
					end
				end
				ate_pkg::FSM_OUT: begin
					if (out_load) begin
						if (op_q == ate_pkg::OP_QUERY && !(c_valid_q && ip_q == c_ip_q) &&
							hit_st_q == ate_pkg::ENT_STABLE) begin
							c_valid_q     <= 1'b1;
							c_idx_valid_q <= 1'b1;
							c_ip_q        <= ip_q;
							c_mac_q       <= hit_mac_q;
							c_idx_q       <= pick_q;
						end else if (op_q == ate_pkg::OP_REPLY && rx_ok) begin
							c_valid_q     <= 1'b1;
							c_ip_q        <= ip_q;
							c_mac_q       <= mac_q;
							if (!c_hit_rx) begin
								c_idx_valid_q <= 1'b1;
								c_idx_q       <= pick_q;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// item capture, scan trackers, decision (payload, no reset)
	always_ff @(posedge clk) begin
		if (st_q == ate_pkg::FSM_IDLE) begin
			op_q  <= ate_pkg::op_t'(s_axis_tdata[1:0]);
			ip_q  <= s_axis_tdata[33:2];
			mac_q <= s_axis_tdata[81:34];
			tgt_q <= s_axis_tdata[113:82];
			rd_idx_q <= '0;
			hit_q <= 1'b0; emp_q <= 1'b0; stb_q <= 1'b0; pnd_q <= 1'b0;
			stb_age_q <= '0; pnd_age_q <= '0;
		end
		if (st_q == ate_pkg::FSM_SCAN) begin
			if (rv_q) begin
				rd_idx_q <= rd_idx_q + AW'(1);
				if (rd_idx_q == c_idx_q) begin
					ce_st_q <= r_state; ce_ip_q <= r_ip; ce_mac_q <= r_mac;
				end
				if (r_state == ate_pkg::ENT_EMPTY) begin
					if (!emp_q) begin
						emp_q <= 1'b1; emp_idx_q <= rd_idx_q;
					end
				end else if (!hit_q) begin
					if (r_ip == ip_q && (r_state == ate_pkg::ENT_PENDING ||
						r_state == ate_pkg::ENT_STABLE)) begin
						hit_q <= 1'b1; hit_idx_q <= rd_idx_q;
						hit_st_q <= r_state; hit_mac_q <= r_mac;
					end else if (r_state == ate_pkg::ENT_PENDING && r_age >= pnd_age_q) begin
						pnd_q <= 1'b1; pnd_idx_q <= rd_idx_q; pnd_age_q <= r_age;
					end else if (r_state == ate_pkg::ENT_STABLE && r_age >= stb_age_q) begin
						stb_q <= 1'b1; stb_idx_q <= rd_idx_q; stb_age_q <= r_age;
					end
				end
			end
		end
		if (st_q == ate_pkg::FSM_DECIDE) begin
			logic          found;
			logic [AW-1:0] p, pk;
			logic [1:0]    pst;
			logic [47:0]   pmac;
			logic [63:0]   res;
			logic          wen;
			logic [ate_pkg::ENTRY_W-1:0] ww;
			found = 1'b1;
			p     = '0;
			pst   = ate_pkg::ENT_EMPTY;
			pmac  = '0;
			if (hit_q) begin
				p = hit_idx_q; pst = hit_st_q; pmac = hit_mac_q;
			end else if (emp_q) p = emp_idx_q;
			else if (stb_q) p = stb_idx_q;
			else if (pnd_q) p = pnd_idx_q;
			else found = 1'b0;
			pk  = p;
			wen = 1'b0;
			ww  = '0;
			res = '0;
			res[2:0] = ate_pkg::ST_TICKDONE;
			case (op_q)
				ate_pkg::OP_TICK: ;
				ate_pkg::OP_QUERY: begin
					if (c_valid_q && ip_q == c_ip_q) begin
						res[2:0]   = ate_pkg::ST_RESOLVED;
						res[50:3]  = c_mac_q;
						res[54:51] = c_idx_valid_q ? 4'(c_idx_q) : 4'd0;
					end else if (!found) begin
						res[2:0] = ate_pkg::ST_FULL;
					end else if (pst == ate_pkg::ENT_STABLE) begin
						res[2:0]   = ate_pkg::ST_RESOLVED;
						res[50:3]  = pmac;
						res[54:51] = 4'(p);
					end else begin
						res[2:0]   = ate_pkg::ST_PENDING;
						res[54:51] = 4'(p);
						res[55]    = 1'b1;
						wen = 1'b1;
						ww  = {8'd0, pmac, ip_q, ate_pkg::ENT_PENDING};
					end
				end
				default: begin
					if (!rx_ok) begin
						res[2:0] = ate_pkg::ST_DROPPED;
					end else if (c_hit_rx) begin
						// cached entry: only its age is zeroed, whatever it holds now
						res[2:0]   = ate_pkg::ST_UPDATED;
						res[54:51] = c_idx_valid_q ? 4'(c_idx_q) : 4'd0;
						res[56]    = (op_q == ate_pkg::OP_REQUEST);
						pk  = c_idx_q;
						wen = c_idx_valid_q;
						ww  = {8'd0, ce_mac_q, ce_ip_q, ce_st_q};
					end else if (!found) begin
						res[2:0] = ate_pkg::ST_FULL;
						res[56]  = (op_q == ate_pkg::OP_REQUEST);
					end else begin
						res[2:0]   = ate_pkg::ST_UPDATED;
						res[54:51] = 4'(p);
						res[56]    = (op_q == ate_pkg::OP_REQUEST);
						wen = 1'b1;
						ww  = {8'd0, mac_q, ip_q, ate_pkg::ENT_STABLE};
					end
				end
			endcase
			if (!hit_q) hit_st_q <= ate_pkg::ENT_EMPTY;
			pick_q    <= pk;
			wen_q     <= wen;
			wword_q   <= ww;
			dec_res_q <= res;
		end
		if (out_load)
			res_q <= dec_res_q;
	end
endmodule
`default_nettype wire
